// ===== rtl/assert_macros.svh =====
// ----------------------------------------------------------------------------
// assertion macros
// shared concurrent assertion helpers, clocked on aclk
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTH
`define ASSERT_IMPLIES(label, ante, cons) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error("assertion failed");
`define ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error("assertion failed");
`define ASSERT_RESET(label, ante, cons) \
    label: assert property (@(posedge aclk) (ante) |-> (cons)) \
        else $error("assertion failed");
`else
`define ASSERT_IMPLIES(label, ante, cons)
`define ASSERT_NEXT(label, ante, cons)
`define ASSERT_RESET(label, ante, cons)
`endif
`endif

// ===== rtl/crs_pkg.sv =====
// ----------------------------------------------------------------------------
// crs_pkg
// widths, types and cofactor tables for the 3x3 solver
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
package crs_pkg;
    localparam int DW = 32;
    localparam int FB = 16;
    localparam int PW = 2 * DW;
    localparam int EW = 3 * DW + 1;
    localparam int MW = 3 * DW;
    localparam int NW = MW + FB;
    localparam int QW = DW + 1;
    localparam int DET_STAGES = 5;
    localparam int DIV_STAGES = QW + 3;
    localparam int LAT = DET_STAGES + DIV_STAGES;

    typedef logic signed [DW-1:0] elem_t;
    typedef elem_t mat_t [9];
    typedef logic signed [EW-1:0] det_t;
    typedef logic [3:0] idx_t;

    typedef struct packed {
        logic [DW-1:0] sol;
        logic          ovf;
        logic          zero;
    } div_res_t;

    localparam idx_t TERM_IDX [6][3] = '{
        '{4'd0, 4'd4, 4'd8}, '{4'd0, 4'd5, 4'd7}, '{4'd1, 4'd3, 4'd8},
        '{4'd1, 4'd5, 4'd6}, '{4'd2, 4'd3, 4'd7}, '{4'd2, 4'd4, 4'd6}
    };
    localparam logic TERM_SUB [6] = '{1'b0, 1'b1, 1'b1, 1'b0, 1'b0, 1'b1};
endpackage
`default_nettype wire

// ===== rtl/crs_det_lane.sv =====
// ----------------------------------------------------------------------------
// crs_det_lane
// exact pipelined 3x3 determinant by cofactor expansion, five stages
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
module crs_det_lane (
    input  wire logic          aclk,
    input  wire logic          en,
    input  crs_pkg::mat_t      a,
    output crs_pkg::det_t      det
);
    logic signed [crs_pkg::PW-1:0] p_reg  [6];
    crs_pkg::elem_t                z_reg  [6];
    logic signed [crs_pkg::PW-1:0] hi_reg [6];
    logic signed [crs_pkg::PW:0]   lo_reg [6];
    crs_pkg::det_t                 term_c [6];
    crs_pkg::det_t                 t_reg  [6];
    crs_pkg::det_t                 s_reg  [3];
    crs_pkg::det_t                 d_reg;

    for (genvar k = 0; k < 6; k++) begin : g_term
        always_comb begin
            term_c[k] = (crs_pkg::EW'(hi_reg[k]) <<< crs_pkg::DW) + crs_pkg::EW'(lo_reg[k]);
        end

        always_ff @(posedge aclk) begin
            if (en) begin
                p_reg[k]  <= a[crs_pkg::TERM_IDX[k][0]] * a[crs_pkg::TERM_IDX[k][1]];
                z_reg[k]  <= a[crs_pkg::TERM_IDX[k][2]];
                hi_reg[k] <= $signed(p_reg[k][crs_pkg::PW-1:crs_pkg::DW]) * z_reg[k];
                lo_reg[k] <= $signed({1'b0, p_reg[k][crs_pkg::DW-1:0]}) * z_reg[k];
                t_reg[k]  <= crs_pkg::TERM_SUB[k] ? -term_c[k] : term_c[k];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            s_reg[0] <= t_reg[0] + t_reg[1];
            s_reg[1] <= t_reg[2] + t_reg[3];
            s_reg[2] <= t_reg[4] + t_reg[5];
            d_reg    <= s_reg[0] + s_reg[1] + s_reg[2];
        end
    end

    assign det = d_reg;
endmodule
`default_nettype wire

// ===== rtl/crs_div_lane.sv =====
// ----------------------------------------------------------------------------
// crs_div_lane
// pipelined restoring divider, one quotient bit per stage, with saturation
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
module crs_div_lane (
    input  wire logic          aclk,
    input  wire logic          en,
    input  crs_pkg::det_t      den,
    input  crs_pkg::det_t      num,
    output crs_pkg::div_res_t  res
);
    localparam int QW = crs_pkg::QW;
    localparam int MW = crs_pkg::MW;
    localparam int NW = crs_pkg::NW;
    localparam logic [QW-1:0] LIM = QW'(1) << (crs_pkg::DW - 1);

    logic [MW-1:0] dmag_a_reg, nmag_a_reg;
    logic          neg_a_reg, zero_a_reg;
    crs_pkg::det_t dabs_c, nabs_c;
    logic [NW-1:0] nsh_c;
    logic [MW-1:0] rtop_c;
    logic          ovf_c;

    logic [MW-1:0] r_reg   [QW+1];
    logic [QW-1:0] q_reg   [QW+1];
    logic [QW-1:0] lo_reg  [QW+1];
    logic [MW-1:0] d_reg   [QW+1];
    logic          neg_reg [QW+1];
    logic          ovf_reg [QW+1];
    logic          zero_reg[QW+1];

    crs_pkg::div_res_t res_reg, res_next;

    always_comb begin
        dabs_c = den[crs_pkg::EW-1] ? -den : den;
        nabs_c = num[crs_pkg::EW-1] ? -num : num;
        nsh_c  = {nmag_a_reg, {crs_pkg::FB{1'b0}}};
        rtop_c = MW'(nsh_c[NW-1:QW]);
        ovf_c  = rtop_c >= dmag_a_reg;
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            dmag_a_reg  <= dabs_c[MW-1:0];
            nmag_a_reg  <= nabs_c[MW-1:0];
            neg_a_reg   <= den[crs_pkg::EW-1] ^ num[crs_pkg::EW-1];
            zero_a_reg  <= (den == '0);
            r_reg[0]    <= ovf_c ? '0 : rtop_c;
            q_reg[0]    <= '0;
            lo_reg[0]   <= nsh_c[QW-1:0];
            d_reg[0]    <= dmag_a_reg;
            neg_reg[0]  <= neg_a_reg;
            ovf_reg[0]  <= ovf_c;
            zero_reg[0] <= zero_a_reg;
        end
    end

    for (genvar j = 0; j < QW; j++) begin : g_bit
        logic [MW:0] t_c;
        logic        ge_c;
        assign t_c  = {r_reg[j], lo_reg[j][QW-1-j]};
        assign ge_c = t_c >= {1'b0, d_reg[j]};

        always_ff @(posedge aclk) begin
            if (en) begin
                r_reg[j+1]           <= ge_c ? MW'(t_c - {1'b0, d_reg[j]}) : t_c[MW-1:0];
                q_reg[j+1]           <= q_reg[j] | (QW'(ge_c) << (QW - 1 - j));
                lo_reg[j+1]          <= lo_reg[j];
                d_reg[j+1]           <= d_reg[j];
                neg_reg[j+1]         <= neg_reg[j];
                ovf_reg[j+1]         <= ovf_reg[j];
                zero_reg[j+1]        <= zero_reg[j];
            end
        end
    end

    always_comb begin
        res_next.zero = zero_reg[QW];
        res_next.ovf  = 1'b0;
        res_next.sol  = '0;
        if (!zero_reg[QW]) begin
            if (!neg_reg[QW]) begin
                if (ovf_reg[QW] || q_reg[QW] >= LIM) begin
                    res_next.ovf = 1'b1;
                    res_next.sol = {1'b0, {(crs_pkg::DW-1){1'b1}}};
                end else begin
                    res_next.sol = q_reg[QW][crs_pkg::DW-1:0];
                end
            end else begin
                if (ovf_reg[QW] || q_reg[QW] > LIM) begin
                    res_next.ovf = 1'b1;
                    res_next.sol = {1'b1, {(crs_pkg::DW-1){1'b0}}};
                end else begin
                    res_next.sol = -q_reg[QW][crs_pkg::DW-1:0];
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            res_reg <= res_next;
        end
    end

    assign res = res_reg;
endmodule
`default_nettype wire

// ===== rtl/cramer_3x3_linear_solver.sv =====
// ----------------------------------------------------------------------------
// cramer_3x3_linear_solver
// throughput: one transaction per cycle while m_ready does not stall the output,
// set by the 5-stage determinant lanes and the 36-stage bit-per-stage divider lanes
// reset clears the valid flags of the pipeline and the result register only
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"
module cramer_3x3_linear_solver (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_valid,
    output      logic        s_ready,
    input  wire logic [31:0] s_m_r0c0,
    input  wire logic [31:0] s_m_r0c1,
    input  wire logic [31:0] s_m_r0c2,
    input  wire logic [31:0] s_m_r1c0,
    input  wire logic [31:0] s_m_r1c1,
    input  wire logic [31:0] s_m_r1c2,
    input  wire logic [31:0] s_m_r2c0,
    input  wire logic [31:0] s_m_r2c1,
    input  wire logic [31:0] s_m_r2c2,
    input  wire logic [31:0] s_rhs_0,
    input  wire logic [31:0] s_rhs_1,
    input  wire logic [31:0] s_rhs_2,
    output      logic        m_valid,
    input  wire logic        m_ready,
    output      logic [31:0] m_sol_0,
    output      logic [31:0] m_sol_1,
    output      logic [31:0] m_sol_2,
    output      logic        m_singular,
    output      logic        m_overflow
);
    localparam int LAT = crs_pkg::LAT;

    crs_pkg::mat_t     mat [4];
    crs_pkg::elem_t    rhs [3];
    crs_pkg::det_t     det [4];
    crs_pkg::div_res_t res [3];

    logic [LAT-1:0] v_reg, v_next;
    logic           m_valid_reg, m_valid_next;
    logic           en;
    logic [crs_pkg::DW-1:0] sol_reg [3];
    logic           singular_reg, overflow_reg;

    assign en = !v_reg[LAT-1] || !m_valid_reg || m_ready;
    assign s_ready = en;

    always_comb begin
        rhs[0] = s_rhs_0;
        rhs[1] = s_rhs_1;
        rhs[2] = s_rhs_2;
        mat[0][0] = s_m_r0c0; mat[0][1] = s_m_r0c1; mat[0][2] = s_m_r0c2;
        mat[0][3] = s_m_r1c0; mat[0][4] = s_m_r1c1; mat[0][5] = s_m_r1c2;
        mat[0][6] = s_m_r2c0; mat[0][7] = s_m_r2c1; mat[0][8] = s_m_r2c2;
        for (int k = 0; k < 3; k++) begin
            for (int i = 0; i < 9; i++) begin
                mat[k+1][i] = ((i % 3) == k) ? rhs[i / 3] : mat[0][i];
            end
        end
    end

    for (genvar l = 0; l < 4; l++) begin : g_det
        crs_det_lane u_det (
            .aclk (aclk),
            .en   (en),
            .a    (mat[l]),
            .det  (det[l])
        );
    end

    for (genvar k = 0; k < 3; k++) begin : g_div
        crs_div_lane u_div (
            .aclk (aclk),
            .en   (en),
            .den  (det[0]),
            .num  (det[k+1]),
            .res  (res[k])
        );
    end

    always_comb begin
        v_next       = {v_reg[LAT-2:0], s_valid};
        m_valid_next = m_valid_reg && !m_ready;
        if (v_reg[LAT-1]) begin
            m_valid_next = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v_reg       <= '0;
            m_valid_reg <= 1'b0;
        end else if (en) begin
            v_reg       <= v_next;
            m_valid_reg <= m_valid_next;
        end
    end

    // merge of the three divider lanes
    always_ff @(posedge aclk) begin
        if (en && v_reg[LAT-1]) begin
            for (int k = 0; k < 3; k++) begin
                sol_reg[k] <= res[k].sol;
            end
            singular_reg <= res[0].zero;
            overflow_reg <= res[0].ovf || res[1].ovf || res[2].ovf;
        end
    end

    assign m_valid    = m_valid_reg;
    assign m_sol_0    = sol_reg[0];
    assign m_sol_1    = sol_reg[1];
    assign m_sol_2    = sol_reg[2];
    assign m_singular = singular_reg;
    assign m_overflow = overflow_reg;

    `ASSERT_IMPLIES(a_singular_zero, m_valid && m_singular, !m_overflow && m_sol_0 == '0 && m_sol_1 == '0 && m_sol_2 == '0)
    `ASSERT_IMPLIES(a_stall_cause, !s_ready, m_valid && !m_ready && v_reg[LAT-1])
    `ASSERT_NEXT(a_result_arrives, en && v_reg[LAT-1], m_valid)
    `ASSERT_RESET(a_reset_clears, $past(!aresetn), !m_valid)
endmodule
`default_nettype wire

// ===== tb/cramer_3x3_linear_solver_tb.sv =====
// ----------------------------------------------------------------------------
// cramer_3x3_linear_solver_tb
// Self-checking bench for the 3x3 fixed-point solver. A directed table covers
// identity, singular and saturating systems and the extreme codes. Random
// systems follow. A local model forms the exact determinants and divides them
// to predict each solution. Both channels idle in random bursts.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
module cramer_3x3_linear_solver_tb;
    localparam int DW = 32;
    localparam int FB = 16;
    localparam int NRAND = 1030;
    localparam int CALM = 150;
    localparam int LIMIT = 400000;
    localparam int TAIL = 60;

    typedef logic signed [DW-1:0] word_t;
    typedef logic signed [3*DW+FB+8:0] wide_t;

    typedef struct {
        word_t m [9];
        word_t r [3];
    } system_t;

    typedef struct {
        word_t x [3];
        logic  sng;
        logic  ovf;
    } solution_t;

    typedef struct {
        system_t   s;
        logic      has_sol;
        solution_t sol;
    } row_t;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_valid = 1'b0;
    logic        s_ready;
    logic [31:0] s_f [12];
    logic        m_valid;
    logic        m_ready = 1'b0;
    logic [31:0] m_sol_0, m_sol_1, m_sol_2;
    logic        m_singular, m_overflow;

    solution_t solutions_due [$];
    row_t      rows [$];
    int        errors = 0;
    int        cycles = 0;
    int        n_sent = 0;
    int        n_got = 0;
    int        n_sng = 0;
    int        n_ovf = 0;
    logic      calm = 1'b0;
    int        idle_m = 0;

    initial s_f = '{default: '0};

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    cramer_3x3_linear_solver i_dut (
        .aclk(aclk), .aresetn(aresetn), .s_valid(s_valid), .s_ready(s_ready),
        .s_m_r0c0(s_f[0]), .s_m_r0c1(s_f[1]), .s_m_r0c2(s_f[2]),
        .s_m_r1c0(s_f[3]), .s_m_r1c1(s_f[4]), .s_m_r1c2(s_f[5]),
        .s_m_r2c0(s_f[6]), .s_m_r2c1(s_f[7]), .s_m_r2c2(s_f[8]),
        .s_rhs_0(s_f[9]), .s_rhs_1(s_f[10]), .s_rhs_2(s_f[11]),
        .m_valid(m_valid), .m_ready(m_ready),
        .m_sol_0(m_sol_0), .m_sol_1(m_sol_1), .m_sol_2(m_sol_2),
        .m_singular(m_singular), .m_overflow(m_overflow)
    );

    function automatic wide_t det3(word_t a [9]);
        wide_t d;
        d = wide_t'(a[0]) * a[4] * a[8] - wide_t'(a[0]) * a[5] * a[7]
          - wide_t'(a[1]) * a[3] * a[8] + wide_t'(a[1]) * a[5] * a[6]
          + wide_t'(a[2]) * a[3] * a[7] - wide_t'(a[2]) * a[4] * a[6];
        return d;
    endfunction

    function automatic solution_t cramer_solve(system_t s);
        solution_t o;
        word_t     c [9];
        wide_t     d, n, q;
        wide_t     hi, lo;
        d = det3(s.m);
        hi = (wide_t'(1) <<< (DW - 1)) - 1;
        lo = -(wide_t'(1) <<< (DW - 1));
        o.sng = (d == 0);
        o.ovf = 1'b0;
        for (int k = 0; k < 3; k++) begin
            o.x[k] = '0;
            if (d != 0) begin
                c = s.m;
                for (int i = 0; i < 3; i++) c[i*3+k] = s.r[i];
                n = det3(c) <<< FB;
                q = n / d;
                if (q > hi) begin
                    o.ovf = 1'b1;
                    o.x[k] = word_t'(hi);
                end else if (q < lo) begin
                    o.ovf = 1'b1;
                    o.x[k] = word_t'(lo);
                end else begin
                    o.x[k] = word_t'(q);
                end
            end
        end
        return o;
    endfunction

    function automatic word_t rand_elem();
        case ($urandom_range(0, 5))
            0: return word_t'($urandom_range(0, 8)) <<< FB;
            1: return -(word_t'($urandom_range(0, 8)) <<< FB);
            2: return word_t'($urandom_range(0, 3)) - 1;
            3: return $urandom_range(0, 1) ? 32'sh7fffffff : 32'sh80000000;
            default: return word_t'($urandom());
        endcase
    endfunction

    function automatic system_t rand_system();
        system_t s;
        for (int i = 0; i < 9; i++) s.m[i] = rand_elem();
        for (int i = 0; i < 3; i++) s.r[i] = rand_elem();
        if ($urandom_range(0, 9) == 0) begin
            // dependent rows force a singular matrix
            for (int i = 0; i < 3; i++) s.m[6+i] = s.m[i];
        end else if ($urandom_range(0, 3) == 0) begin
            // well-conditioned diagonal-dominant system
            for (int i = 0; i < 9; i++) s.m[i] = word_t'($urandom()) >>> 14;
            for (int i = 0; i < 3; i++) s.m[i*4] = 32'sh00400000 + (s.m[i*4] & 32'hffff);
        end
        return s;
    endfunction

    function automatic system_t mk(word_t a, word_t b, word_t d, word_t r);
        system_t s;
        s.m = '{a, b, b, b, a, b, b, b, d};
        s.r = '{r, r, r};
        return s;
    endfunction

    task automatic add_row(system_t s, logic hs, solution_t e);
        row_t w;
        w.s = s;
        w.has_sol = hs;
        w.sol = e;
        rows.push_back(w);
    endtask

    task automatic send_system(system_t s);
        if (!calm && $urandom_range(0, 5) == 0) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(1, 11)) @(posedge aclk);
        end
        s_valid <= 1'b1;
        for (int i = 0; i < 9; i++) s_f[i] <= s.m[i];
        for (int i = 0; i < 3; i++) s_f[9+i] <= s.r[i];
        do @(posedge aclk); while (!s_ready);
        n_sent++;
    endtask

    // expected results queued at acceptance
    always @(posedge aclk) begin
        if (aresetn && s_valid && s_ready) begin
            system_t s;
            for (int i = 0; i < 9; i++) s.m[i] = s_f[i];
            for (int i = 0; i < 3; i++) s.r[i] = s_f[9+i];
            solutions_due.push_back(cramer_solve(s));
        end
    end

    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (aresetn && m_valid && m_ready) begin
            solution_t e;
            n_got++;
            if (solutions_due.size() == 0) begin
                $display("%0t: unexpected result transaction", $time);
                errors++;
            end else begin
                e = solutions_due.pop_front();
                if (m_singular) n_sng++;
                if (m_overflow) n_ovf++;
                if ({m_sol_0, m_sol_1, m_sol_2, m_singular, m_overflow} !==
                    {e.x[0], e.x[1], e.x[2], e.sng, e.ovf}) begin
                    $display("%0t: mismatch expected %h %h %h s%b o%b actual %h %h %h s%b o%b",
                             $time, e.x[0], e.x[1], e.x[2], e.sng, e.ovf,
                             m_sol_0, m_sol_1, m_sol_2, m_singular, m_overflow);
                    errors++;
                end
            end
        end
        if (!aresetn || calm) begin
            m_ready <= aresetn;
        end else if (idle_m > 0) begin
            idle_m <= idle_m - 1;
            m_ready <= 1'b0;
        end else if ($urandom_range(0, 7) == 0) begin
            idle_m <= $urandom_range(0, 10);
            m_ready <= 1'b0;
        end else begin
            m_ready <= 1'b1;
        end
        if (cycles > LIMIT) begin
            $display("cramer_3x3_linear_solver test failed");
            $finish;
        end
    end

    initial begin
        solution_t z, e, p;
        system_t   s;
        z.x = '{0, 0, 0};
        z.sng = 1'b1;
        z.ovf = 1'b0;
        // identity with rhs copied out
        s = mk(32'sh00010000, 0, 32'sh00010000, 32'sh00030000);
        e.x = '{32'sh00030000, 32'sh00030000, 32'sh00030000};
        e.sng = 0;
        e.ovf = 0;
        add_row(s, 1, e);
        add_row(mk(0, 0, 0, 32'sh7fffffff), 1, z);
        add_row(mk(32'sh80000000, 32'sh80000000, 32'sh80000000, 1), 1, z);
        add_row(mk(32'sh7fffffff, 32'sh7fffffff, 32'sh7fffffff, -1), 1, z);
        // tiny identity, large rhs saturates
        s = mk(1, 0, 1, 32'sh7fffffff);
        e.x = '{32'sh7fffffff, 32'sh7fffffff, 32'sh7fffffff};
        e.ovf = 1;
        add_row(s, 1, e);
        s = mk(1, 0, 1, 32'sh80000000);
        e.x = '{32'sh80000000, 32'sh80000000, 32'sh80000000};
        add_row(s, 1, e);
        s = mk(-1, 0, -1, 32'sh80000000);
        e.x = '{32'sh7fffffff, 32'sh7fffffff, 32'sh7fffffff};
        add_row(s, 1, e);
        add_row(mk(32'sh80000000, 0, 32'sh80000000, 32'sh80000000), 0, e);
        add_row(mk(32'sh7fffffff, 32'sh80000000, 32'sh7fffffff, 32'sh7fffffff), 0, e);
        add_row(mk(32'sh00020000, 32'sh00010000, 32'sh00030000, 32'shfffe8000), 0, e);
        add_row(mk(32'sh00030000, 32'sh00010000, 32'sh00010000, 32'sh00010001), 0, e);
        add_row(mk(32'sh00008000, 0, 32'shffff8000, 32'sh00000001), 0, e);

        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        while (rows.size() > 0) begin
            if (rows[0].has_sol) begin
                // typed-in check of directed rows against the predictor
                p = cramer_solve(rows[0].s);
                if ({p.x[0], p.x[1], p.x[2], p.sng, p.ovf} !==
                    {rows[0].sol.x[0], rows[0].sol.x[1], rows[0].sol.x[2],
                     rows[0].sol.sng, rows[0].sol.ovf}) begin
                    $display("%0t: directed row expected %h %h %h s%b o%b predictor %h %h %h",
                             $time, rows[0].sol.x[0], rows[0].sol.x[1], rows[0].sol.x[2],
                             rows[0].sol.sng, rows[0].sol.ovf, p.x[0], p.x[1], p.x[2]);
                    errors++;
                end
            end
            send_system(rows[0].s);
            void'(rows.pop_front());
        end
        for (int n = 0; n < NRAND; n++) begin
            if (n == NRAND / 2) begin
                s_valid <= 1'b0;
                @(posedge aclk);
                while (solutions_due.size() > 0) @(posedge aclk);
            end
            if (n == NRAND - CALM) calm = 1'b1;
            send_system(rand_system());
        end
        s_valid <= 1'b0;
        @(posedge aclk);
        while (solutions_due.size() > 0) @(posedge aclk);
        repeat (TAIL) @(posedge aclk);
        $display("%0d systems sent, %0d solutions checked", n_sent, n_got);
        $display("%0d singular and %0d saturated solutions seen", n_sng, n_ovf);
        if (errors == 0) begin
            $display("cramer_3x3_linear_solver test passed");
        end else begin
            $display("cramer_3x3_linear_solver test failed");
        end
        $finish;
    end
endmodule

// ===== files.f =====
+incdir+rtl
rtl/crs_pkg.sv
rtl/crs_det_lane.sv
rtl/crs_div_lane.sv
rtl/cramer_3x3_linear_solver.sv
tb/cramer_3x3_linear_solver_tb.sv
